@@ hw/rtl/cli_pkg.sv @@
// Types and constants shared by the calibrated loop interpolator modules.
package cli_pkg;

   localparam int PCT_W   = 7;
   localparam int LOOPS_W = 31;
   localparam int CPU_W4  = 4;
   localparam int PIDX_W  = 4;
   // Dividend of the interpolation: 31-bit loop difference times 7-bit offset.
   localparam int PROD_W  = LOOPS_W + PCT_W;

   typedef enum logic {
      CMD_LOAD  = 1'b0,
      CMD_QUERY = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      STS_INTERP     = 3'd0,
      STS_EXACT      = 3'd1,
      STS_CLAMP_HIGH = 3'd2,
      STS_CLAMP_LOW  = 3'd3,
      STS_INVALID    = 3'd4
   } status_type;

   typedef struct packed {
      cmd_type                    cmd;
      logic signed [CPU_W4-1:0]   cpu;
      logic [PIDX_W-1:0]          point_index;
      logic [PCT_W-1:0]           percent;
      logic [LOOPS_W-1:0]         loops;
      logic                       last_point;
   } req_type;

   typedef struct packed {
      logic [LOOPS_W-1:0] loop_count;
      status_type         status;
   } rsp_type;

   typedef enum logic [1:0] {
      RD_LAST,
      RD_FIRST,
      RD_SCAN
   } rd_sel_type;

   typedef enum logic [1:0] {
      EMIT_ZERO,
      EMIT_POINT,
      EMIT_QUOT
   } emit_sel_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_EV_LAST,
      S_EV_FIRST,
      S_RD_SCAN,
      S_EV_SCAN,
      S_MUL,
      S_DIV,
      S_FIN
   } state_type;

   typedef struct packed {
      logic         accept;
      logic         scan_clr;
      logic         rd_en;
      rd_sel_type   rd_sel;
      logic         scan_step;
      logic         mul;
      logic         div_step;
      logic         emit;
      emit_sel_type emit_sel;
      status_type   emit_status;
   } ctl_type;

   typedef struct packed {
      logic query_ok;
      logic above;
      logic below;
      logic equal;
      logic scan_last;
      logic div_done;
   } sts_type;

endpackage

@@ hw/rtl/cli_ctrl.sv @@
// Sequencing state machine of the calibrated loop interpolator.
module cli_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  cli_pkg::cmd_type  cmd,
   input  cli_pkg::sts_type  sts,
   output logic              busy,
   output cli_pkg::ctl_type  ctl
);
   import cli_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      ctl             = '0;
      ctl.rd_sel      = RD_SCAN;
      ctl.emit_sel    = EMIT_ZERO;
      ctl.emit_status = STS_INVALID;
      busy            = (state_ff != S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            ctl.accept = start;
            if (start && cmd == CMD_QUERY) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            ctl.scan_clr = 1'b1;
            if (!sts.query_ok) begin
               ctl.emit = 1'b1;
               state_in = S_IDLE;
            end else begin
               ctl.rd_en  = 1'b1;
               ctl.rd_sel = RD_LAST;
               state_in   = S_EV_LAST;
            end
         end
         S_EV_LAST: begin
            if (sts.above) begin
               ctl.emit        = 1'b1;
               ctl.emit_sel    = EMIT_POINT;
               ctl.emit_status = STS_CLAMP_HIGH;
               state_in        = S_IDLE;
            end else begin
               ctl.rd_en  = 1'b1;
               ctl.rd_sel = RD_FIRST;
               state_in   = S_EV_FIRST;
            end
         end
         S_EV_FIRST: begin
            if (sts.below) begin
               ctl.emit        = 1'b1;
               ctl.emit_sel    = EMIT_POINT;
               ctl.emit_status = STS_CLAMP_LOW;
               state_in        = S_IDLE;
            end else begin
               ctl.rd_en = 1'b1;
               state_in  = S_EV_SCAN;
            end
         end
         S_RD_SCAN: begin
            ctl.rd_en = 1'b1;
            state_in  = S_EV_SCAN;
         end
         S_EV_SCAN: begin
            ctl.scan_step = 1'b1;
            priority if (sts.equal) begin
               ctl.emit        = 1'b1;
               ctl.emit_sel    = EMIT_POINT;
               ctl.emit_status = STS_EXACT;
               state_in        = S_IDLE;
            end else if (sts.scan_last) begin
               state_in = S_MUL;
            end else begin
               state_in = S_RD_SCAN;
            end
         end
         S_MUL: begin
            ctl.mul  = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            ctl.div_step = 1'b1;
            if (sts.div_done) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            ctl.emit        = 1'b1;
            ctl.emit_sel    = EMIT_QUOT;
            ctl.emit_status = STS_INTERP;
            state_in        = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

@@ hw/rtl/cli_dpath.sv @@
// Datapath: point tables, bracket search registers, multiplier and divider.
module cli_dpath #(
   parameter int NUM_CPUS   = 8,
   parameter int MAX_POINTS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  cli_pkg::req_type  req_data,
   input  cli_pkg::ctl_type  ctl,
   output cli_pkg::sts_type  sts,
   output logic              rsp_strobe,
   output cli_pkg::rsp_type  rsp_data
);
   import cli_pkg::*;

   localparam int CPU_W  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
   localparam int IDX_W  = $clog2(MAX_POINTS);
   localparam int CNT_W  = $clog2(MAX_POINTS + 1);
   localparam int DEPTH  = NUM_CPUS * MAX_POINTS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int STEP_W = $clog2(PROD_W + 1);
   localparam int WORD_W = PCT_W + LOOPS_W;

   // Point memory: percent in the upper bits, loop count below.
   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rd_word_ff;

   logic [CNT_W-1:0]  count_ff [NUM_CPUS];

   logic [CPU_W4-1:0] qcpu_ff;
   logic [PCT_W-1:0]  qpct_ff;
   logic [IDX_W-1:0]  scan_ff;
   logic [LOOPS_W-1:0] lo_ff, hi_ff;
   logic [PCT_W-1:0]  lop_ff, hip_ff;
   logic              have_high_ff;
   logic              neg_ff;
   logic [PCT_W-1:0]  den_ff;
   logic [PCT_W-1:0]  rem_ff;
   logic [PROD_W-1:0] quo_ff;
   logic [STEP_W-1:0] step_ff;
   logic              rsp_strobe_ff;
   rsp_type           rsp_ff;

   logic              wr_ok;
   logic [31:0]       wr_addr_full;
   logic [31:0]       rd_addr_full;
   logic [31:0]       base_full;
   logic [CPU_W-1:0]  wcpu, qcpu;
   logic [CNT_W-1:0]  qcount;
   logic              qcpu_ok;
   logic [PCT_W-1:0]  rd_pct;
   logic [LOOPS_W-1:0] rd_loops;
   logic [LOOPS_W:0]  diff;
   logic [LOOPS_W-1:0] mag;
   logic [PCT_W-1:0]  offs;
   logic [PCT_W:0]    trial;
   logic [LOOPS_W:0]  interp;

   assign wcpu = CPU_W'(req_data.cpu[CPU_W4-2:0]);
   assign qcpu = CPU_W'(qcpu_ff[CPU_W4-2:0]);

   // A load names a CPU and a point position that exist.
   assign wr_ok = !req_data.cpu[CPU_W4-1]
                  && (32'(req_data.cpu[CPU_W4-2:0]) < 32'(NUM_CPUS))
                  && (32'(req_data.point_index) < 32'(MAX_POINTS));
   assign wr_addr_full = 32'(req_data.cpu[CPU_W4-2:0]) * 32'(MAX_POINTS)
                         + 32'(req_data.point_index);

   assign qcpu_ok = !qcpu_ff[CPU_W4-1]
                    && (32'(qcpu_ff[CPU_W4-2:0]) < 32'(NUM_CPUS));
   assign qcount  = qcpu_ok ? count_ff[qcpu] : '0;
   assign base_full = 32'(qcpu_ff[CPU_W4-2:0]) * 32'(MAX_POINTS);

   always_comb begin
      unique case (ctl.rd_sel)
         RD_LAST:  rd_addr_full = base_full + 32'(qcount) - 32'd1;
         RD_FIRST: rd_addr_full = base_full;
         default:  rd_addr_full = base_full + 32'(scan_ff);
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.accept && req_data.cmd == CMD_LOAD && wr_ok) begin
         mem[wr_addr_full[ADDR_W-1:0]] <= {req_data.percent, req_data.loops};
      end
      if (ctl.rd_en) begin
         rd_word_ff <= mem[rd_addr_full[ADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CPUS; c++) begin
            count_ff[c] <= '0;
         end
      end else if (ctl.accept && req_data.cmd == CMD_LOAD && wr_ok
                   && req_data.last_point) begin
         count_ff[wcpu] <= CNT_W'(32'(req_data.point_index) + 32'd1);
      end
   end

   assign rd_pct   = rd_word_ff[WORD_W-1:LOOPS_W];
   assign rd_loops = rd_word_ff[LOOPS_W-1:0];

   assign sts.query_ok  = qcpu_ok && (qcount != '0);
   assign sts.above     = qpct_ff > rd_pct;
   assign sts.below     = qpct_ff < rd_pct;
   assign sts.equal     = qpct_ff == rd_pct;
   assign sts.scan_last = (CNT_W'(scan_ff) + CNT_W'(1)) == qcount;
   assign sts.div_done  = step_ff == STEP_W'(1);

   // Signed loop difference and positive percent offset for the product.
   assign diff = {1'b0, hi_ff} - {1'b0, lo_ff};
   assign mag  = diff[LOOPS_W] ? LOOPS_W'(-diff) : diff[LOOPS_W-1:0];
   assign offs = qpct_ff - lop_ff;

   // One restoring division step per cycle; the divisor stays below 128.
   assign trial  = {rem_ff, quo_ff[PROD_W-1]} - {1'b0, den_ff};
   assign interp = neg_ff ? ({1'b0, lo_ff} - {1'b0, quo_ff[LOOPS_W-1:0]})
                          : ({1'b0, lo_ff} + {1'b0, quo_ff[LOOPS_W-1:0]});

   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         qcpu_ff <= req_data.cpu;
         qpct_ff <= req_data.percent;
      end
      if (ctl.scan_clr) begin
         scan_ff      <= '0;
         have_high_ff <= 1'b0;
      end
      if (ctl.scan_step) begin
         scan_ff <= scan_ff + IDX_W'(1);
         if (rd_pct < qpct_ff) begin
            lo_ff  <= rd_loops;
            lop_ff <= rd_pct;
         end else if (rd_pct > qpct_ff && !have_high_ff) begin
            hi_ff        <= rd_loops;
            hip_ff       <= rd_pct;
            have_high_ff <= 1'b1;
         end
      end
      if (ctl.mul) begin
         quo_ff  <= PROD_W'(mag) * PROD_W'(offs);
         neg_ff  <= diff[LOOPS_W];
         den_ff  <= hip_ff - lop_ff;
         rem_ff  <= '0;
         step_ff <= STEP_W'(PROD_W);
      end
      if (ctl.div_step) begin
         step_ff <= step_ff - STEP_W'(1);
         if (!trial[PCT_W]) begin
            rem_ff <= trial[PCT_W-1:0];
            quo_ff <= {quo_ff[PROD_W-2:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[PCT_W-2:0], quo_ff[PROD_W-1]};
            quo_ff <= {quo_ff[PROD_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= ctl.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.emit) begin
         rsp_ff.status <= ctl.emit_status;
         unique case (ctl.emit_sel)
            EMIT_POINT: rsp_ff.loop_count <= rd_loops;
            EMIT_QUOT:  rsp_ff.loop_count <= interp[LOOPS_W-1:0];
            default:    rsp_ff.loop_count <= '0;
         endcase
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

@@ hw/rtl/calibrated_loop_interpolator_unit.sv @@
// Top level of the calibrated loop interpolator: controller and datapath.
//
//   Channel    Ports                     Handshake
//   request    start, busy, req_data     taken when start is high and busy low
//   response   rsp_strobe, rsp_data      shown for one cycle, cannot be held off
//
// A load request is written in the cycle it is taken and busy never rises.
// A query runs as a sequence: a validity check, reads of the last and first
// points, then a scan of the stored points through the single read port of
// the point memory, a multiply and a 38-step restoring division, one quotient
// bit per cycle. Clamped and invalid queries end before the scan. Busy stays
// high until a query ends, so no new request is taken during one. The response
// appears the cycle after the query ends, and the next request may be taken in
// that same cycle. Reset clears the point counts, the controller state and the
// response strobe; the point memory holds whatever was last written.
module calibrated_loop_interpolator_unit #(
   parameter int NUM_CPUS   = 8,
   parameter int MAX_POINTS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  cli_pkg::req_type  req_data,
   output logic              rsp_strobe,
   output cli_pkg::rsp_type  rsp_data
);
   import cli_pkg::*;

   ctl_type ctl;
   sts_type sts;

   // The controller only sequences; all storage and arithmetic sit in the datapath.
   cli_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .cmd   (req_data.cmd),
      .sts   (sts),
      .busy  (busy),
      .ctl   (ctl)
   );

   cli_dpath #(
      .NUM_CPUS   (NUM_CPUS),
      .MAX_POINTS (MAX_POINTS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .ctl        (ctl),
      .sts        (sts),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule
